// ----- src/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent holds -> consequent holds in the next cycle.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/mfs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package mfs_pkg;

    localparam int MAX_TASKS = 16;
    localparam int BURSTS    = 3;
    localparam int NLEVELS   = 3;
    localparam int SLOT_W    = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int DATA_W    = 8;
    localparam int QDEPTH    = NLEVELS * MAX_TASKS;
    localparam int QADDR_W   = $clog2(QDEPTH);
    localparam int BDEPTH    = MAX_TASKS * BURSTS;
    localparam int BADDR_W   = $clog2(BDEPTH);

    localparam logic [1:0] REQ_ADD  = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_IO   = 2'd2;
    localparam logic [1:0] REQ_FIN  = 2'd3;

    localparam logic [2:0] EV_IDLE     = 3'd0;
    localparam logic [2:0] EV_FRESH    = 3'd1;
    localparam logic [2:0] EV_CONT     = 3'd2;
    localparam logic [2:0] EV_EXPIRED  = 3'd3;
    localparam logic [2:0] EV_BURST    = 3'd4;
    localparam logic [2:0] EV_ADDED    = 3'd5;
    localparam logic [2:0] EV_FULL     = 3'd6;
    localparam logic [2:0] EV_REMOVED  = 3'd7;

    localparam logic [1:0] PH_NEW   = 2'd0;
    localparam logic [1:0] PH_READY = 2'd1;
    localparam logic [1:0] PH_RUN   = 2'd2;
    localparam logic [1:0] PH_WAIT  = 2'd3;

    localparam logic [1:0] CFG_Q1  = 2'd0;
    localparam logic [1:0] CFG_Q2  = 2'd1;
    localparam logic [1:0] CFG_Q3  = 2'd2;
    localparam logic [1:0] CFG_IOW = 2'd3;

    localparam logic [1:0] QOP_PUSH   = 2'd0;
    localparam logic [1:0] QOP_FIND   = 2'd1;
    localparam logic [1:0] QOP_REMOVE = 2'd2;

    typedef struct packed {
        logic              valid;
        logic [1:0]        op;
        logic [1:0]        lvl;
        logic [SLOT_W-1:0] slot;
    } t_qcmd;

    typedef struct packed {
        logic              done;
        logic              found;
        logic [SLOT_W-1:0] slot;
    } t_qsts;

    function automatic logic [BADDR_W-1:0] burst_addr(input logic [SLOT_W-1:0] slot,
                                                      input logic [1:0] idx);
        burst_addr = BADDR_W'(BADDR_W'(slot) * BADDR_W'(BURSTS) + BADDR_W'(idx));
    endfunction

endpackage
`default_nettype wire

// ----- src/mfs_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface mfs_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] burst_first;
    logic [7:0] burst_second;
    logic [7:0] burst_third;

    modport source (output valid, req_type, burst_first, burst_second, burst_third,
                    input ready);
    modport sink (input valid, req_type, burst_first, burst_second, burst_third,
                  output ready);
endinterface

interface mfs_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_code;
    logic [3:0] task_slot;
    logic [1:0] task_level;
    logic [1:0] burst_number;
    logic [7:0] time_remaining;
    logic       all_empty;
    logic       last_result;

    modport source (output valid, event_code, task_slot, task_level, burst_number,
                    time_remaining, all_empty, last_result, input ready);
    modport sink (input valid, event_code, task_slot, task_level, burst_number,
                  time_remaining, all_empty, last_result, output ready);
endinterface
`default_nettype wire

// ----- src/mfs_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 48,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ----- src/mfs_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mfs_queue (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire mfs_pkg::t_qcmd                   i_cmd,
    input  wire logic [mfs_pkg::MAX_TASKS-1:0]    i_ready_mask,
    output mfs_pkg::t_qsts                        o_sts
);
    localparam logic [2:0] Q_IDLE = 3'd0;
    localparam logic [2:0] Q_SRD  = 3'd1;
    localparam logic [2:0] Q_SCHK = 3'd2;
    localparam logic [2:0] Q_MRD  = 3'd3;
    localparam logic [2:0] Q_MWR  = 3'd4;

    localparam int CW = mfs_pkg::CNT_W;
    localparam int SW = mfs_pkg::SLOT_W;
    localparam int AW = mfs_pkg::QADDR_W;

    logic [2:0]    r_state;
    logic [1:0]    r_op;
    logic [1:0]    r_lvl;
    logic [SW-1:0] r_slot;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_cnt [mfs_pkg::NLEVELS];
    logic          r_done;
    logic          r_found;
    logic [SW-1:0] r_fslot;

    logic          q_we, q_re;
    logic [AW-1:0] q_waddr, q_raddr;
    logic [SW-1:0] q_wdata, q_rdata;
    logic [CW-1:0] idx_nx;
    logic          match;
    logic          n_done;

    function automatic logic [AW-1:0] q_addr(input logic [1:0] lvl, input logic [CW-1:0] idx);
        q_addr = AW'(AW'(lvl) * AW'(mfs_pkg::MAX_TASKS) + AW'(idx));
    endfunction

    assign idx_nx = r_idx + CW'(1);
    assign match  = (r_op == mfs_pkg::QOP_FIND) ? i_ready_mask[q_rdata] : (q_rdata == r_slot);

    always_comb begin
        case (r_state)
            Q_IDLE:  n_done = i_cmd.valid && (i_cmd.op == mfs_pkg::QOP_PUSH);
            Q_SRD:   n_done = !(r_idx < r_cnt[r_lvl]);
            Q_SCHK:  n_done = match && (r_op == mfs_pkg::QOP_FIND);
            Q_MRD:   n_done = !(idx_nx < r_cnt[r_lvl]);
            default: n_done = 1'b0;
        endcase
    end

    always_comb begin
        q_we    = 1'b0;
        q_re    = 1'b0;
        q_waddr = q_addr(i_cmd.lvl, r_cnt[i_cmd.lvl]);
        q_wdata = i_cmd.slot;
        q_raddr = q_addr(r_lvl, r_idx);
        case (r_state)
            Q_IDLE: begin
                q_we = i_cmd.valid && (i_cmd.op == mfs_pkg::QOP_PUSH)
                       && (r_cnt[i_cmd.lvl] < CW'(mfs_pkg::MAX_TASKS));
            end
            Q_SRD: begin
                q_re = r_idx < r_cnt[r_lvl];
            end
            Q_MRD: begin
                q_re    = idx_nx < r_cnt[r_lvl];
                q_raddr = q_addr(r_lvl, idx_nx);
            end
            Q_MWR: begin
                q_we    = 1'b1;
                q_waddr = q_addr(r_lvl, r_idx);
                q_wdata = q_rdata;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= Q_IDLE;
            r_done  <= 1'b0;
            r_found <= 1'b0;
            for (int i = 0; i < mfs_pkg::NLEVELS; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_done <= n_done;
            case (r_state)
                Q_IDLE: begin
                    if (i_cmd.valid) begin
                        r_op   <= i_cmd.op;
                        r_lvl  <= i_cmd.lvl;
                        r_slot <= i_cmd.slot;
                        r_idx  <= '0;
                        if (i_cmd.op == mfs_pkg::QOP_PUSH) begin
                            if (r_cnt[i_cmd.lvl] < CW'(mfs_pkg::MAX_TASKS)) begin
                                r_cnt[i_cmd.lvl] <= r_cnt[i_cmd.lvl] + CW'(1);
                            end
                        end else begin
                            r_state <= Q_SRD;
                        end
                    end
                end
                Q_SRD: begin
                    if (r_idx < r_cnt[r_lvl]) begin
                        r_state <= Q_SCHK;
                    end else begin
                        r_found <= 1'b0;
                        r_state <= Q_IDLE;
                    end
                end
                Q_SCHK: begin
                    if (match) begin
                        if (r_op == mfs_pkg::QOP_FIND) begin
                            r_found <= 1'b1;
                            r_fslot <= q_rdata;
                            r_state <= Q_IDLE;
                        end else begin
                            r_state <= Q_MRD;
                        end
                    end else begin
                        r_idx   <= idx_nx;
                        r_state <= Q_SRD;
                    end
                end
                Q_MRD: begin
                    if (idx_nx < r_cnt[r_lvl]) begin
                        r_state <= Q_MWR;
                    end else begin
                        // close the gap left by the removed entry
                        r_cnt[r_lvl] <= r_cnt[r_lvl] - CW'(1);
                        r_state      <= Q_IDLE;
                    end
                end
                Q_MWR: begin
                    r_idx   <= idx_nx;
                    r_state <= Q_MRD;
                end
                default: r_state <= Q_IDLE;
            endcase
        end
    end

    mfs_ram #(.WIDTH(SW), .DEPTH(mfs_pkg::QDEPTH)) u_qram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_re    (q_re),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    assign o_sts.done  = r_done;
    assign o_sts.found = r_found;
    assign o_sts.slot  = r_fslot;

    `ASSERT_IMP(a_cmd_when_idle, i_clk, i_rst_n, i_cmd.valid, r_state == Q_IDLE)
    `ASSERT_NXT(a_push_one_cycle, i_clk, i_rst_n,
                i_cmd.valid && (i_cmd.op == mfs_pkg::QOP_PUSH), r_done && (r_state == Q_IDLE))
    `ASSERT_IMP(a_state_legal, i_clk, i_rst_n, 1'b1, r_state <= Q_MWR)
endmodule
`default_nettype wire

// ----- src/multilevel_feedback_scheduler.sv -----
// One result per request. Add scans for the first free slot (or reports full), writes its
// bursts and pushes it onto the level-1 list; finish and I/O may remove a queue entry,
// shifting later entries down one by one. Tick time is set by the queue engine walking
// level lists one entry at a time through its memory. One request in flight at a time.
// Reset (synchronous, active low) empties all slots and level lists and loads the
// default quanta 1, 2, 4 and I/O wait 3.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module multilevel_feedback_scheduler (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [7:0] i_cfg_data,
    mfs_req_if.sink         i_req,
    mfs_res_if.source       o_res
);
    localparam int NT = mfs_pkg::MAX_TASKS;
    localparam int SW = mfs_pkg::SLOT_W;
    localparam int CW = mfs_pkg::CNT_W;
    localparam int BW = mfs_pkg::BADDR_W;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_AFIND  = 5'd1;
    localparam logic [4:0] S_AWR    = 5'd2;
    localparam logic [4:0] S_APUSH  = 5'd3;
    localparam logic [4:0] S_QWAIT  = 5'd4;
    localparam logic [4:0] S_TSEL   = 5'd5;
    localparam logic [4:0] S_TREM   = 5'd6;
    localparam logic [4:0] S_TPUSH  = 5'd7;
    localparam logic [4:0] S_TFIND  = 5'd8;
    localparam logic [4:0] S_TFWAIT = 5'd9;
    localparam logic [4:0] S_TRDL   = 5'd10;
    localparam logic [4:0] S_TCHK   = 5'd11;
    localparam logic [4:0] S_SLEEP  = 5'd12;
    localparam logic [4:0] S_IO     = 5'd13;
    localparam logic [4:0] S_FIN    = 5'd14;
    localparam logic [4:0] S_FREM   = 5'd15;
    localparam logic [4:0] S_FRD    = 5'd16;
    localparam logic [4:0] S_FOUT   = 5'd17;

    logic [4:0]    r_state, r_ret;
    logic [7:0]    r_q1, r_q2, r_q3, r_iow;

    logic [NT-1:0] r_used;
    logic [1:0]    r_phase [NT];
    logic [1:0]    r_level [NT];
    logic [7:0]    r_timer [NT];
    logic          r_moved [NT];
    logic          r_back  [NT];
    logic [1:0]    r_bidx  [NT];

    logic [SW-1:0] r_run_slot;
    logic          r_run_valid;
    logic [1:0]    r_active;
    logic [7:0]    r_qused;

    logic [1:0]    r_req_type;
    logic [7:0]    r_b0, r_b1, r_b2;
    logic [SW-1:0] r_s;
    logic [2:0]    r_ev;
    logic          r_has;
    logic [CW-1:0] r_k;
    logic [1:0]    r_b;
    logic [1:0]    r_lvl, r_nl;
    logic          r_fresh, r_sleep;

    logic          r_out_valid;
    logic [2:0]    r_o_ev;
    logic [SW-1:0] r_o_slot;
    logic [1:0]    r_o_lvl, r_o_bidx;
    logic [7:0]    r_o_left;
    logic          r_o_empty;

    logic [NT-1:0] rdy_mask, wait_mask;
    logic [2:0]    lvl_has;
    logic          any_ready, any_wait;
    logic [1:0]    t_lvl;
    logic [7:0]    qmax, qz, qu_eff;
    logic [1:0]    cur_bidx;
    logic [7:0]    tmr_inc [NT];
    logic          out_load;

    logic          b_we, b_re;
    logic [BW-1:0] b_waddr, b_raddr;
    logic [7:0]    b_wdata, b_rdata, add_burst;

    mfs_pkg::t_qcmd qcmd;
    mfs_pkg::t_qsts qsts;

    always_comb begin
        lvl_has = '0;
        for (int i = 0; i < NT; i++) begin
            rdy_mask[i]  = r_used[i] && (r_phase[i] == mfs_pkg::PH_NEW
                                         || r_phase[i] == mfs_pkg::PH_READY);
            wait_mask[i] = r_used[i] && (r_phase[i] == mfs_pkg::PH_WAIT);
            tmr_inc[i]   = r_timer[i] + 8'd1;
            lvl_has[0]   = lvl_has[0] | (rdy_mask[i] && r_level[i] == 2'd1);
            lvl_has[1]   = lvl_has[1] | (rdy_mask[i] && r_level[i] == 2'd2);
            lvl_has[2]   = lvl_has[2] | (rdy_mask[i] && r_level[i] == 2'd3);
        end
    end

    assign any_ready = |rdy_mask;
    assign any_wait  = |wait_mask;

    always_comb begin
        if ((r_active == 2'd0 && lvl_has[0]) || r_active == 2'd1) begin
            t_lvl = 2'd1;
        end else if ((r_active == 2'd0 && lvl_has[1]) || r_active == 2'd2) begin
            t_lvl = 2'd2;
        end else if ((r_active == 2'd0 && lvl_has[2]) || r_active == 2'd3) begin
            t_lvl = 2'd3;
        end else begin
            t_lvl = 2'd0;
        end
        case (t_lvl)
            2'd1:    qmax = r_q1;
            2'd2:    qmax = r_q2;
            default: qmax = r_q3;
        endcase
    end

    assign qz       = (qmax == 8'd0) ? 8'd1 : qmax;
    assign qu_eff   = (r_active == 2'd0) ? 8'd0 : r_qused;
    assign cur_bidx = r_bidx[r_s];
    assign out_load = (r_state == S_FOUT) && (!r_out_valid || o_res.ready);

    always_comb begin
        case (r_b)
            2'd0:    add_burst = r_b0;
            2'd1:    add_burst = r_b1;
            2'd2:    add_burst = r_b2;
            default: add_burst = 8'd0;
        endcase
    end

    always_comb begin
        b_we    = 1'b0;
        b_waddr = mfs_pkg::burst_addr(r_s, r_b);
        b_wdata = add_burst;
        b_re    = 1'b0;
        b_raddr = mfs_pkg::burst_addr(r_s, cur_bidx);
        case (r_state)
            S_AWR: b_we = 1'b1;
            S_TRDL, S_FRD: b_re = 1'b1;
            S_TCHK: begin
                b_we    = b_rdata != 8'd0;
                b_waddr = mfs_pkg::burst_addr(r_s, cur_bidx);
                b_wdata = b_rdata - 8'd1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        qcmd = '0;
        case (r_state)
            S_APUSH: begin
                qcmd.valid = 1'b1;
                qcmd.op    = mfs_pkg::QOP_PUSH;
                qcmd.lvl   = 2'd0;
                qcmd.slot  = r_s;
            end
            S_TREM, S_FREM: begin
                qcmd.valid = 1'b1;
                qcmd.op    = mfs_pkg::QOP_REMOVE;
                qcmd.lvl   = r_lvl - 2'd1;
                qcmd.slot  = r_s;
            end
            S_TPUSH: begin
                qcmd.valid = 1'b1;
                qcmd.op    = mfs_pkg::QOP_PUSH;
                qcmd.lvl   = r_nl - 2'd1;
                qcmd.slot  = r_s;
            end
            S_TFIND: begin
                qcmd.valid = 1'b1;
                qcmd.op    = mfs_pkg::QOP_FIND;
                qcmd.lvl   = r_lvl - 2'd1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_q1        <= 8'd1;
            r_q2        <= 8'd2;
            r_q3        <= 8'd4;
            r_iow       <= 8'd3;
            r_used      <= '0;
            r_run_slot  <= '0;
            r_run_valid <= 1'b0;
            r_active    <= 2'd0;
            r_qused     <= 8'd0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NT; i++) begin
                r_phase[i] <= mfs_pkg::PH_NEW;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mfs_pkg::CFG_Q1: r_q1  <= i_cfg_data;
                    mfs_pkg::CFG_Q2: r_q2  <= i_cfg_data;
                    mfs_pkg::CFG_Q3: r_q3  <= i_cfg_data;
                    default:         r_iow <= i_cfg_data;
                endcase
            end
            if (r_out_valid && o_res.ready && !out_load) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_req_type <= i_req.req_type;
                        r_b0       <= i_req.burst_first;
                        r_b1       <= i_req.burst_second;
                        r_b2       <= i_req.burst_third;
                        r_k        <= '0;
                        r_sleep    <= 1'b0;
                        case (i_req.req_type)
                            mfs_pkg::REQ_ADD:  r_state <= S_AFIND;
                            mfs_pkg::REQ_TICK: r_state <= S_TSEL;
                            mfs_pkg::REQ_IO:   r_state <= S_IO;
                            default:           r_state <= S_FIN;
                        endcase
                    end
                end
                S_AFIND: begin
                    if (r_k == CW'(NT)) begin
                        r_ev    <= mfs_pkg::EV_FULL;
                        r_has   <= 1'b0;
                        r_state <= S_FRD;
                    end else if (!r_used[r_k[SW-1:0]]) begin
                        r_s                     <= r_k[SW-1:0];
                        r_used[r_k[SW-1:0]]     <= 1'b1;
                        r_phase[r_k[SW-1:0]]    <= mfs_pkg::PH_NEW;
                        r_level[r_k[SW-1:0]]    <= 2'd1;
                        r_timer[r_k[SW-1:0]]    <= 8'd0;
                        r_moved[r_k[SW-1:0]]    <= 1'b0;
                        r_back[r_k[SW-1:0]]     <= 1'b0;
                        r_bidx[r_k[SW-1:0]]     <= 2'd0;
                        r_b                     <= 2'd0;
                        r_ev                    <= mfs_pkg::EV_ADDED;
                        r_has                   <= 1'b1;
                        r_state                 <= S_AWR;
                    end else begin
                        r_k <= r_k + CW'(1);
                    end
                end
                S_AWR: begin
                    if (r_b == 2'(mfs_pkg::BURSTS - 1)) begin
                        r_state <= S_APUSH;
                    end else begin
                        r_b <= r_b + 2'd1;
                    end
                end
                S_APUSH: begin
                    r_ret   <= S_FRD;
                    r_state <= S_QWAIT;
                end
                S_QWAIT: begin
                    if (qsts.done) begin
                        r_state <= r_ret;
                    end
                end
                S_TSEL: begin
                    if (t_lvl == 2'd0) begin
                        r_ev    <= mfs_pkg::EV_IDLE;
                        r_has   <= 1'b0;
                        r_state <= S_SLEEP;
                    end else if (qu_eff >= qz) begin
                        r_lvl       <= t_lvl;
                        r_run_valid <= 1'b0;
                        r_qused     <= 8'd0;
                        r_active    <= 2'd0;
                        if (r_run_valid) begin
                            // demote one level, level 3 rotates to its own tail
                            r_s                 <= r_run_slot;
                            r_nl                <= (t_lvl < 2'd3) ? t_lvl + 2'd1 : 2'd3;
                            r_level[r_run_slot] <= (t_lvl < 2'd3) ? t_lvl + 2'd1 : 2'd3;
                            if (t_lvl < 2'd3) begin
                                r_moved[r_run_slot] <= 1'b1;
                            end
                            r_phase[r_run_slot] <= mfs_pkg::PH_READY;
                            r_ev                <= mfs_pkg::EV_EXPIRED;
                            r_has               <= 1'b1;
                            r_state             <= S_TREM;
                        end else begin
                            r_ev    <= mfs_pkg::EV_IDLE;
                            r_has   <= 1'b0;
                            r_state <= S_SLEEP;
                        end
                    end else begin
                        r_lvl    <= t_lvl;
                        r_active <= t_lvl;
                        r_qused  <= qu_eff;
                        if (!r_run_valid) begin
                            r_state <= S_TFIND;
                        end else begin
                            r_moved[r_run_slot] <= 1'b0;
                            r_s                 <= r_run_slot;
                            r_fresh             <= 1'b0;
                            r_state             <= S_TRDL;
                        end
                    end
                end
                S_TREM: begin
                    r_ret   <= S_TPUSH;
                    r_state <= S_QWAIT;
                end
                S_TPUSH: begin
                    r_ret   <= (r_req_type == mfs_pkg::REQ_TICK) ? S_SLEEP : S_FRD;
                    r_state <= S_QWAIT;
                end
                S_TFIND: begin
                    r_state <= S_TFWAIT;
                end
                S_TFWAIT: begin
                    if (qsts.done) begin
                        if (qsts.found) begin
                            r_run_slot  <= qsts.slot;
                            r_run_valid <= 1'b1;
                            r_s         <= qsts.slot;
                            r_fresh     <= 1'b1;
                            r_state     <= S_TRDL;
                        end else begin
                            r_active <= 2'd0;
                            r_ev     <= mfs_pkg::EV_IDLE;
                            r_has    <= 1'b0;
                            r_state  <= S_FRD;
                        end
                    end
                end
                S_TRDL: begin
                    r_state <= S_TCHK;
                end
                S_TCHK: begin
                    r_has <= 1'b1;
                    if (b_rdata == 8'd0) begin
                        // empty burst: step to the next one, hold at the last
                        if (3'(cur_bidx) + 3'd1 < 3'(mfs_pkg::BURSTS)) begin
                            r_bidx[r_s] <= cur_bidx + 2'd1;
                        end
                        r_ev    <= mfs_pkg::EV_BURST;
                        r_state <= S_FRD;
                    end else begin
                        if (r_fresh) begin
                            r_back[r_s]  <= 1'b0;
                            r_phase[r_s] <= mfs_pkg::PH_RUN;
                            r_ev         <= mfs_pkg::EV_FRESH;
                        end else begin
                            r_ev <= mfs_pkg::EV_CONT;
                        end
                        r_qused <= r_qused + 8'd1;
                        r_sleep <= 1'b1;
                        r_state <= S_SLEEP;
                    end
                end
                S_SLEEP: begin
                    if (r_sleep || (!any_ready && any_wait)) begin
                        for (int i = 0; i < NT; i++) begin
                            if (wait_mask[i]) begin
                                if (tmr_inc[i] == r_iow) begin
                                    r_phase[i] <= mfs_pkg::PH_READY;
                                    r_timer[i] <= 8'd0;
                                    r_back[i]  <= 1'b1;
                                end else begin
                                    r_timer[i] <= tmr_inc[i];
                                end
                            end
                        end
                    end
                    r_state <= S_FRD;
                end
                S_IO: begin
                    r_s         <= r_run_slot;
                    r_has       <= r_run_valid;
                    r_ev        <= mfs_pkg::EV_IDLE;
                    r_active    <= 2'd0;
                    r_run_valid <= 1'b0;
                    if (r_run_valid && !r_moved[r_run_slot]
                        && (r_active == 2'd2 || r_active == 2'd3)) begin
                        r_state <= S_TREM;
                    end else begin
                        r_state <= S_FRD;
                    end
                    if (r_run_valid) begin
                        r_phase[r_run_slot] <= mfs_pkg::PH_WAIT;
                        r_timer[r_run_slot] <= 8'd0;
                        // promote one level from level 2 or 3 unless it was just demoted
                        if (!r_moved[r_run_slot] && (r_active == 2'd2 || r_active == 2'd3)) begin
                            r_level[r_run_slot] <= r_active - 2'd1;
                            r_lvl               <= r_active;
                            r_nl                <= r_active - 2'd1;
                        end
                    end
                end
                S_FIN: begin
                    if (r_run_valid) begin
                        r_s                 <= r_run_slot;
                        r_lvl               <= (r_level[r_run_slot] == 2'd0)
                                               ? 2'd1 : r_level[r_run_slot];
                        r_used[r_run_slot]  <= 1'b0;
                        r_phase[r_run_slot] <= mfs_pkg::PH_NEW;
                        r_run_valid         <= 1'b0;
                        r_active            <= 2'd0;
                        r_ev                <= mfs_pkg::EV_REMOVED;
                        r_has               <= 1'b1;
                        r_state             <= S_FREM;
                    end else begin
                        r_ev    <= mfs_pkg::EV_IDLE;
                        r_has   <= 1'b0;
                        r_state <= S_FRD;
                    end
                end
                S_FREM: begin
                    r_ret   <= S_FRD;
                    r_state <= S_QWAIT;
                end
                S_FRD: begin
                    r_state <= S_FOUT;
                end
                S_FOUT: begin
                    if (out_load) begin
                        r_out_valid <= 1'b1;
                        r_o_ev      <= r_ev;
                        r_o_slot    <= r_has ? r_s : '0;
                        r_o_lvl     <= r_has ? r_level[r_s] : 2'd0;
                        r_o_bidx    <= r_has ? cur_bidx : 2'd0;
                        r_o_left    <= r_has ? b_rdata : 8'd0;
                        r_o_empty   <= ~|r_used;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    mfs_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (qcmd),
        .i_ready_mask (rdy_mask),
        .o_sts        (qsts)
    );

    mfs_ram #(.WIDTH(mfs_pkg::DATA_W), .DEPTH(mfs_pkg::BDEPTH)) u_bram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_re    (b_re),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_res.valid          = r_out_valid;
    assign o_res.event_code     = r_o_ev;
    assign o_res.task_slot      = r_o_slot;
    assign o_res.task_level     = r_o_lvl;
    assign o_res.burst_number   = r_o_bidx;
    assign o_res.time_remaining = r_o_left;
    assign o_res.all_empty      = r_o_empty;
    assign o_res.last_result    = 1'b1;

    `ASSERT_IMP(a_run_has_level, i_clk, i_rst_n, r_run_valid, r_active != 2'd0)
    `ASSERT_NXT(a_result_loaded, i_clk, i_rst_n, out_load,
                r_out_valid && (r_state == S_IDLE))
    `ASSERT_IMP(a_state_legal, i_clk, i_rst_n, 1'b1, r_state <= S_FOUT)
endmodule
`default_nettype wire
